[sv/mfd_pkg.sv]
// ----------------------------------------------------------------------------
// mfd_pkg
// shared types and constants of the matrix frame deserializer
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned HeaderLen  = 8;

    localparam logic [7:0] MAGIC [0:3] = '{8'h50, 8'h41, 8'h32, 8'h4D};

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_ELEM   = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_BAD_MAGIC  = 3'd2,
        ST_RESERVED   = 3'd3,
        ST_ZERO_IDENT = 3'd4,
        ST_ZERO_DIM   = 3'd5,
        ST_NOT_SQUARE = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        FILL_EXPLICIT = 2'd0,
        FILL_ZEROS    = 2'd1,
        FILL_IDENTITY = 2'd2
    } fill_t;

    // one queue entry: an optional header or element result and an optional end result
    typedef struct packed {
        logic        has_main;
        kind_t       main_kind;
        status_t     main_status;
        fill_t       fill;
        logic        row_major;
        logic [7:0]  elem_row;
        logic [7:0]  elem_col;
        logic [63:0] elem_value;
        logic        has_end;
        status_t     end_status;
        logic [7:0]  rows;
        logic [7:0]  cols;
    } entry_t;

    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [7:0]  row_total;
        logic [7:0]  col_total;
        fill_t       fill_mode;
        logic        row_major_in;
        logic [7:0]  elem_row;
        logic [7:0]  elem_col;
        logic [63:0] elem_value;
        logic        last_result;
    } result_t;

endpackage

[sv/matrix_frame_deserializer.sv]
// ----------------------------------------------------------------------------
// matrix_frame_deserializer
// parses a serialized matrix frame byte by byte into header, element and end beats
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle. The parser checks the 8-byte header, assembles
// big-endian 64-bit elements and tracks row and column (column-major frames are
// mapped back), then writes each beat-producing byte into a queue of
// QUEUE_DEPTH entries. The output register drains one result per cycle while
// out_ready is high; a last byte that also completes the header or an element
// yields two beats from one entry, kept queued until both are sent. Input stalls
// only when the queue is full, so a ready output sustains one byte per cycle.
module matrix_frame_deserializer
#(
    parameter int unsigned QUEUE_DEPTH = mfd_pkg::QueueDepth
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, row_total, col_total, fill_mode, row_major_in, elem_row, elem_col,
    // elem_value, zero pad
    output logic [103:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast    // last_result
);
    import mfd_pkg::*;

    entry_t  wr_entry;
    entry_t  rd_entry;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    logic    accept;
    result_t result;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mfd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .push      (push),
        .entry     (wr_entry)
    );

    mfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .full     (full),
        .empty    (empty)
    );

    mfd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .entry     (rd_entry),
        .empty     (empty),
        .pop       (pop),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .result    (result)
    );

    assign m_axis_tdata = {2'b00, result.elem_value, result.elem_col, result.elem_row,
                           result.row_major_in, result.fill_mode, result.col_total,
                           result.row_total, result.status};
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.last_result;

endmodule

[sv/mfd_front.sv]
// ----------------------------------------------------------------------------
// mfd_front
// byte parser: header checks, element assembly, row and column tracking
// ----------------------------------------------------------------------------
module mfd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              push,
    output mfd_pkg::entry_t   entry
);
    import mfd_pkg::*;

    logic [3:0]  hdr_pos_reg, hdr_pos_next;
    logic [7:0]  props_hi_reg, props_hi_next;
    fill_t       fill_reg, fill_next;
    logic        rm_reg, rm_next;
    logic [7:0]  rows_reg, rows_next;
    logic [7:0]  cols_reg, cols_next;
    status_t     err_reg, err_next;
    logic [55:0] shift_reg, shift_next;
    logic [2:0]  bcnt_reg, bcnt_next;
    logic [7:0]  row_reg, row_next;
    logic [7:0]  col_reg, col_next;
    logic        done_reg, done_next;

    logic        in_header;
    logic        payload_active;
    logic        elem_done;
    logic        hdr_done;
    logic [7:0]  row_inc;
    logic [7:0]  col_inc;
    status_t     end_status;

    assign in_header      = !hdr_pos_reg[3];
    assign payload_active = !in_header && (err_reg == ST_OK) && (fill_reg == FILL_EXPLICIT)
                            && !done_reg;
    assign elem_done      = payload_active && (bcnt_reg == 3'd7);
    assign hdr_done       = in_header && (hdr_pos_reg == 4'(HeaderLen - 1));
    assign row_inc        = row_reg + 8'd1;
    assign col_inc        = col_reg + 8'd1;

    always_comb
    begin
        hdr_pos_next  = hdr_pos_reg;
        props_hi_next = props_hi_reg;
        fill_next     = fill_reg;
        rm_next       = rm_reg;
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        err_next      = err_reg;
        shift_next    = shift_reg;
        bcnt_next     = bcnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        done_next     = done_reg;

        if (in_header)
        begin
            hdr_pos_next = hdr_pos_reg + 4'd1;
            case (hdr_pos_reg)
                4'd0, 4'd1, 4'd2, 4'd3:
                begin
                    if (data_byte != MAGIC[hdr_pos_reg[1:0]] && err_next == ST_OK)
                        err_next = ST_BAD_MAGIC;
                end
                4'd4:
                    props_hi_next = data_byte;
                4'd5:
                begin
                    rm_next = data_byte[0];
                    if ((props_hi_reg != 8'd0 || data_byte[7:3] != 5'd0)
                        && err_next == ST_OK)
                        err_next = ST_RESERVED;
                    if (data_byte[1] && data_byte[2] && err_next == ST_OK)
                        err_next = ST_ZERO_IDENT;
                    if (data_byte[2])
                        fill_next = FILL_IDENTITY;
                    else if (data_byte[1])
                        fill_next = FILL_ZEROS;
                    else
                        fill_next = FILL_EXPLICIT;
                end
                4'd6:
                    rows_next = data_byte;
                default:
                begin
                    cols_next = data_byte;
                    if (rows_reg == 8'd0 || data_byte == 8'd0)
                    begin
                        if (err_next == ST_OK)
                            err_next = ST_ZERO_DIM;
                    end
                    else if (fill_reg == FILL_IDENTITY && rows_reg != data_byte
                             && err_next == ST_OK)
                        err_next = ST_NOT_SQUARE;
                    if (err_next != ST_OK)
                        fill_next = FILL_EXPLICIT;
                end
            endcase
        end
        else if (payload_active)
        begin
            if (!elem_done)
            begin
                shift_next = {shift_reg[47:0], data_byte};
                bcnt_next  = bcnt_reg + 3'd1;
            end
            else
            begin
                shift_next = '0;
                bcnt_next  = '0;
                if (rm_reg)
                begin
                    col_next = col_inc;
                    if (col_inc >= cols_reg)
                    begin
                        col_next = '0;
                        row_next = row_inc;
                        if (row_inc >= rows_reg)
                            done_next = 1'b1;
                    end
                end
                else
                begin
                    row_next = row_inc;
                    if (row_inc >= rows_reg)
                    begin
                        row_next = '0;
                        col_next = col_inc;
                        if (col_inc >= cols_reg)
                            done_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (hdr_pos_next[3] == 1'b0)
            end_status = ST_SHORT;
        else if (err_next != ST_OK)
            end_status = err_next;
        else if (fill_next == FILL_EXPLICIT && !done_next)
            end_status = ST_SHORT;
        else
            end_status = ST_OK;
    end

    always_comb
    begin
        entry.has_main    = hdr_done || elem_done;
        entry.main_kind   = hdr_done ? KIND_HEADER : KIND_ELEM;
        entry.main_status = hdr_done ? err_next : ST_OK;
        entry.fill        = hdr_done ? fill_next : FILL_EXPLICIT;
        entry.row_major   = rm_next;
        entry.elem_row    = hdr_done ? 8'd0 : row_reg;
        entry.elem_col    = hdr_done ? 8'd0 : col_reg;
        entry.elem_value  = hdr_done ? 64'd0 : {shift_reg, data_byte};
        entry.has_end     = last_byte;
        entry.end_status  = end_status;
        entry.rows        = rows_next;
        entry.cols        = cols_next;
    end

    assign push = accept && (hdr_done || elem_done || last_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg  <= '0;
            props_hi_reg <= '0;
            fill_reg     <= FILL_EXPLICIT;
            rm_reg       <= 1'b0;
            rows_reg     <= '0;
            cols_reg     <= '0;
            err_reg      <= ST_OK;
            shift_reg    <= '0;
            bcnt_reg     <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                hdr_pos_reg  <= '0;
                props_hi_reg <= '0;
                fill_reg     <= FILL_EXPLICIT;
                rm_reg       <= 1'b0;
                rows_reg     <= '0;
                cols_reg     <= '0;
                err_reg      <= ST_OK;
                shift_reg    <= '0;
                bcnt_reg     <= '0;
                row_reg      <= '0;
                col_reg      <= '0;
                done_reg     <= 1'b0;
            end
            else
            begin
                hdr_pos_reg  <= hdr_pos_next;
                props_hi_reg <= props_hi_next;
                fill_reg     <= fill_next;
                rm_reg       <= rm_next;
                rows_reg     <= rows_next;
                cols_reg     <= cols_next;
                err_reg      <= err_next;
                shift_reg    <= shift_next;
                bcnt_reg     <= bcnt_next;
                row_reg      <= row_next;
                col_reg      <= col_next;
                done_reg     <= done_next;
            end
        end
    end

endmodule

[sv/mfd_fifo.sv]
// ----------------------------------------------------------------------------
// mfd_fifo
// short queue of parsed entries between parser and output stage
// ----------------------------------------------------------------------------
module mfd_fifo
#(
    parameter int unsigned DEPTH = mfd_pkg::QueueDepth
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mfd_pkg::entry_t   wr_entry,
    input  logic              pop,
    output mfd_pkg::entry_t   rd_entry,
    output logic              full,
    output logic              empty
);
    import mfd_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    entry_t          mem [0:DEPTH-1];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CntW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign rd_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CntW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/mfd_back.sv]
// ----------------------------------------------------------------------------
// mfd_back
// output stage: expands each queue entry into one or two result beats
// ----------------------------------------------------------------------------
module mfd_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  mfd_pkg::entry_t   entry,
    input  logic              empty,
    output logic              pop,
    input  logic              out_ready,
    output logic              out_valid,
    output mfd_pkg::result_t  result
);
    import mfd_pkg::*;

    logic    valid_reg, valid_next;
    logic    main_sent_reg, main_sent_next;
    result_t res_reg, res_next;
    logic    load;
    logic    send_main;

    assign load      = !valid_reg || out_ready;
    assign send_main = entry.has_main && !main_sent_reg;

    always_comb
    begin
        valid_next     = valid_reg;
        main_sent_next = main_sent_reg;
        res_next       = res_reg;
        pop            = 1'b0;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                if (send_main)
                begin
                    res_next.kind         = entry.main_kind;
                    res_next.status       = entry.main_status;
                    res_next.fill_mode    = entry.fill;
                    res_next.row_major_in = entry.row_major;
                    res_next.elem_row     = entry.elem_row;
                    res_next.elem_col     = entry.elem_col;
                    res_next.elem_value   = entry.elem_value;
                    res_next.last_result  = 1'b0;
                    if (entry.has_end)
                        main_sent_next = 1'b1;
                    else
                        pop = 1'b1;
                end
                else
                begin
                    res_next.kind         = KIND_END;
                    res_next.status       = entry.end_status;
                    res_next.fill_mode    = FILL_EXPLICIT;
                    res_next.row_major_in = 1'b0;
                    res_next.elem_row     = '0;
                    res_next.elem_col     = '0;
                    res_next.elem_value   = '0;
                    res_next.last_result  = 1'b1;
                    main_sent_next        = 1'b0;
                    pop                   = 1'b1;
                end
                res_next.row_total = entry.rows;
                res_next.col_total = entry.cols;
            end
        end
    end

    assign out_valid = valid_reg;
    assign result    = res_reg;

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            main_sent_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            main_sent_reg <= main_sent_next;
        end
    end

endmodule
